/* rtl/wbps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; used by wbps_cell and wildcard_byte_pattern_scan.
package wbps_pkg;

  localparam int MAX_PATTERN_DEF   = 16;
  localparam int OFFSET_BITS_DEF   = 32;
  localparam int PATTERN_REG_BYTES = 16;
  localparam int LEN_W             = 5;
  localparam int CFG_INDEX_W       = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_BASE    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } out_item_t;

  // Per-cycle control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

/* rtl/wildcard_byte_pattern_scan.sv */
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern scanner: a chain of window cells,
// a result stage and an output register. Depends on wbps_pkg and wbps_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_item  (data_byte, last_byte)
//  out     | output    | out_valid/out_stall| out_item (found, match_address)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; the cell chain shifts and
// all window compares run in parallel in the accept cycle. A result passes through
// two registers before it reaches out: the result stage registers the hit and start
// offset, and the output register takes the region base added to that offset.
// Reset (rst_n low, synchronous) clears the window, offset, pipeline and
// registers; pattern_length resets to 1. in_stall rises only when both the
// result stage and the output register are full and out_stall is high.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  wbps_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output wbps_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);
  import wbps_pkg::*;

  // Longest pattern the chain can test
  localparam int LIM = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN : PATTERN_REG_BYTES;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  // Configuration registers
  logic [63:0]      pattern_low_r;
  logic [63:0]      pattern_high_r;
  logic [15:0]      care_mask_r;
  logic [LEN_W-1:0] pattern_length_r;
  logic [63:0]      region_base_r;

  // Scan state
  logic [OFFSET_BITS-1:0] offset_r;
  logic [OFFSET_BITS-1:0] offset_nxt;
  logic                   reported_r;
  logic                   reported_nxt;

  // Result stage and output register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_found_r;
  logic [OFFSET_BITS-1:0] s1_start_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;
  out_item_t              out_item_nxt;

  logic             in_fire;
  logic             advance_out;
  logic [LEN_W-1:0] eff_len;
  logic [7:0]       pat_bytes [PATTERN_REG_BYTES];
  logic [OFFSET_BITS-1:0] offset_inc;
  logic [OFFSET_BITS-1:0] len_ext;
  logic             window_hit;
  logic             match_now;
  logic             produce;
  cell_ctrl_t       cell_ctrl;

  logic [7:0] cell_in   [MAX_PATTERN];
  logic [7:0] cell_out  [MAX_PATTERN];
  logic [7:0] cell_pat  [MAX_PATTERN];
  logic       cell_care [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  // ---------------------------------------------------------------------
  // Configuration port: always ready, unknown indexes are dropped
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= 64'd0;
      pattern_high_r   <= 64'd0;
      care_mask_r      <= 16'd0;
      pattern_length_r <= LEN_W'(1);
      region_base_r    <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        CFG_CARE_MASK:      care_mask_r      <= cfg_data[15:0];
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        CFG_REGION_BASE:    region_base_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the length: zero means one, cap at the chain's reach
  always_comb begin
    priority if (pattern_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(LIM)) begin
      eff_len = LEN_W'(LIM);
    end else begin
      eff_len = pattern_length_r;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pat_bytes[b]     = pattern_low_r[8*b +: 8];
      pat_bytes[b + 8] = pattern_high_r[8*b +: 8];
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes: advance the output when it is empty or being taken
  // ---------------------------------------------------------------------
  assign advance_out = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !advance_out;
  assign in_fire     = in_valid && !in_stall;

  assign cell_ctrl.shift = in_fire;
  assign cell_ctrl.clear = in_fire && in_item.last_byte;

  // ---------------------------------------------------------------------
  // Cell chain: cell 0 takes the new byte, each cell hands its byte on.
  // Cell i lines up with pattern byte len-1-i; cells past len always hit.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = in_item.data_byte;
    end else begin : g_link
      assign cell_in[i] = cell_out[i-1];
    end

    if (i < LIM) begin : g_cmp
      logic [LEN_W-1:0] k;
      assign k            = LEN_W'(eff_len - LEN_W'(i + 1));
      assign cell_pat[i]  = pat_bytes[k[3:0]];
      assign cell_care[i] = (LEN_W'(i) < eff_len) && care_mask_r[k[3:0]];
    end else begin : g_nocmp
      assign cell_pat[i]  = 8'd0;
      assign cell_care[i] = 1'b0;
    end

    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .byte_in  (cell_in[i]),
      .pat_byte (cell_pat[i]),
      .care     (cell_care[i]),
      .byte_out (cell_out[i]),
      .hit      (cell_hit[i])
    );
  end

  assign window_hit = &cell_hit;

  // ---------------------------------------------------------------------
  // Offset count, saturating, and the match decision for this item
  // ---------------------------------------------------------------------
  assign offset_inc = (offset_r == OFFSET_MAX) ? offset_r : offset_r + OFFSET_BITS'(1);
  assign len_ext    = OFFSET_BITS'(eff_len);
  assign match_now  = !reported_r && (offset_inc >= len_ext) && window_hit;
  assign produce    = match_now || (!reported_r && in_item.last_byte);

  always_comb begin
    offset_nxt   = offset_r;
    reported_nxt = reported_r;
    if (in_fire) begin
      if (in_item.last_byte) begin
        offset_nxt   = '0;
        reported_nxt = 1'b0;
      end else begin
        offset_nxt   = offset_inc;
        reported_nxt = reported_r || match_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      reported_r <= 1'b0;
    end else begin
      offset_r   <= offset_nxt;
      reported_r <= reported_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result stage: hold hit flag and start offset; drain into the output
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (in_fire && produce) begin
      s1_valid_nxt = 1'b1;
    end else if (advance_out) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && produce) begin
      s1_found_r <= match_now;
      s1_start_r <= offset_inc - len_ext;
    end
  end

  // Add the region base; a miss reports address zero
  always_comb begin
    out_item_nxt.found         = s1_found_r;
    out_item_nxt.match_address = s1_found_r ? region_base_r + 64'(s1_start_r) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/wbps_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds one byte of the sliding window and compares the
// byte entering it against its pattern byte. Depends on wbps_pkg.
module wbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          byte_in,
  input  logic [7:0]          pat_byte,
  input  logic                care,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import wbps_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    priority if (ctrl.clear) begin
      byte_nxt = 8'd0;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end else begin
      byte_nxt = byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // Compare the incoming byte: that is the value this cell holds after a shift without a clear
  assign hit      = !care || (byte_in == pat_byte);
  assign byte_out = byte_r;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_scan: directed and random byte regions
// are scored against an in-bench model of the masked pattern search.
// Depends on wbps_pkg and the scanner RTL; reads no files.
module tb_top;
  import wbps_pkg::*;

  localparam int MAX_PAT       = MAX_PATTERN_DEF;
  localparam int OFF_W         = OFFSET_BITS_DEF;
  localparam int IDLE_PCT      = 34;    // chance in a hundred that a side idles in a cycle
  localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES = 8;     // pipeline is two deep; leave slack
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off in the backpressure test
  localparam int PHASE_ITEMS   = 160;
  localparam int RANDOM_PHASES = 8;
  localparam int STEADY_PHASE  = 3;     // random phase run without any idling

  typedef enum int {REGION_NOISE, REGION_PLANT, REGION_BROKEN} region_mode_t;

  // DUT ports; every input starts at a known value
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data  = '0;

  // Scanner model: register copies (reset values) and per-region state
  logic [63:0]      pat_low   = '0;
  logic [63:0]      pat_high  = '0;
  logic [15:0]      care_bits = '0;
  logic [4:0]       pat_len   = 5'd1;
  logic [63:0]      base_addr = '0;
  logic [7:0]       scan_window [MAX_PAT];
  logic [OFF_W-1:0] scan_count;
  logic             hit_given;

  // Reports the scanner owes us, oldest first
  out_item_t pending_reports [$];
  out_item_t want_report;

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  int  hold_request = 0;
  int  hold_left    = 0;
  bit  steady       = 1'b0;   // set: neither side idles

  wildcard_byte_pattern_scan i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Clear the window, byte count and report flag at the end of a region
  function automatic void rearm_window();
    foreach (scan_window[i]) scan_window[i] = '0;
    scan_count = '0;
    hit_given  = 1'b0;
  endfunction

  // Pattern length in use: zero counts as one, oversize clamps to the window
  function automatic int active_length();
    int len;
    len = pat_len;
    if (len == 0) len = 1;
    if (len > PATTERN_REG_BYTES) len = PATTERN_REG_BYTES;
    if (len > MAX_PAT) len = MAX_PAT;
    return len;
  endfunction

  function automatic logic [7:0] pattern_at(input int k);
    return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
  endfunction

  // Pattern byte 0 lines up with the oldest of the last len bytes
  function automatic bit window_hit(input int len);
    for (int k = 0; k < len; k++) begin
      if (care_bits[k] && scan_window[len-1-k] != pattern_at(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [63:0] val);
    case (idx)
      CFG_PATTERN_LOW:    pat_low   = val;
      CFG_PATTERN_HIGH:   pat_high  = val;
      CFG_CARE_MASK:      care_bits = val[15:0];
      CFG_PATTERN_LENGTH: pat_len   = val[4:0];
      CFG_REGION_BASE:    base_addr = val;
      default: ;
    endcase
  endfunction

  // Advance the model by one accepted byte and queue the report it causes, if any
  function automatic void scan_byte(input in_item_t it);
    int        len;
    out_item_t rep;
    len = active_length();
    for (int i = MAX_PAT - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
    scan_window[0] = it.data_byte;
    if (scan_count != '1) scan_count++;   // saturate
    if (!hit_given) begin
      if (scan_count >= OFF_W'(len) && window_hit(len)) begin
        rep.found         = 1'b1;
        rep.match_address = base_addr + 64'(scan_count) - 64'(len);
        hit_given         = 1'b1;
        pending_reports   = {pending_reports, rep};
      end else if (it.last_byte) begin
        rep             = '0;
        pending_reports = {pending_reports, rep};
      end
    end
    if (it.last_byte) rearm_window();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall driver
  // Handshakes are sampled at the edge, before any update scheduled at it.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: found=%0b match_address=%h",
               out_item.found, out_item.match_address);
        mismatches++;
      end else begin
        want_report = pending_reports.pop_front();
        if (out_item.found !== want_report.found) begin
          $error("found: expected %0b, actual %0b", want_report.found, out_item.found);
          mismatches++;
        end
        if (out_item.match_address !== want_report.match_address) begin
          $error("match_address: expected %h, actual %h",
                 want_report.match_address, out_item.match_address);
          mismatches++;
        end
      end
    end
    // Pick up a hold-off request and count it down here
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run when no channel moves an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wildcard_byte_pattern_scan: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; each is entered just after a rising edge
  // ---------------------------------------------------------------------------

  // Offer one item, idling at random first; hold it until accepted
  task automatic offer_byte(input logic [7:0] d, input logic lst);
    in_item_t it;
    it.data_byte = d;
    it.last_byte = lst;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(it);
  endtask

  // Drop valid and wait until every owed report has come back
  task automatic wait_reports_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Drain, then let bytes that cause no report leave the pipeline
  task automatic settle();
    wait_reports_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_register(idx, val);
  endtask

  // Write all five registers while idle, sometimes with a write to an unused index
  task automatic program_scan(input logic [63:0] pl, ph, cm, ln, bs);
    settle();
    write_reg(CFG_PATTERN_LOW, pl);
    write_reg(CFG_PATTERN_HIGH, ph);
    write_reg(CFG_CARE_MASK, cm);
    write_reg(CFG_PATTERN_LENGTH, ln);
    if ($urandom_range(1) == 1)
      write_reg(CFG_REGION_BASE + CFG_INDEX_W'($urandom_range(3, 1)), rand64());
    write_reg(CFG_REGION_BASE, bs);
    cfg_valid <= 1'b0;
  endtask

  // Random setting; upper data bits stay random to exercise field masking
  task automatic program_random();
    logic [63:0] cm, ln, bs;
    int          pick;
    cm   = rand64();
    pick = $urandom_range(3);
    case (pick)
      0: cm[15:0] = '1;
      1: cm[15:0] = '0;
      2: cm[15:0] = cm[15:0] & cm[31:16];   // sparse care bits
      default: ;
    endcase
    ln   = rand64();
    pick = $urandom_range(9);
    if (pick == 0)      ln[4:0] = 5'd0;
    else if (pick == 1) ln[4:0] = 5'($urandom_range(31, 17));
    else if (pick == 2) ln[4:0] = 5'd16;
    else                ln[4:0] = 5'($urandom_range(16, 1));
    pick = $urandom_range(4);
    bs   = (pick == 0) ? 64'd0 : (pick == 1) ? '1 : rand64();
    program_scan(rand64(), rand64(), cm, ln, bs);
  endtask

  // Send one region of n bytes. Plant the pattern at a random fitting spot, plant it
  // with one cared byte flipped, or send plain noise.
  task automatic send_region(input int n, input region_mode_t mode);
    int         len, pos, flip_k, k;
    logic [7:0] b;
    len    = active_length();
    pos    = -1;
    flip_k = -1;
    if (mode != REGION_NOISE && n >= len) begin
      pos = $urandom_range(n - len, 0);
      if (mode == REGION_BROKEN && (int'(care_bits) & ((1 << len) - 1)) != 0) begin
        do flip_k = $urandom_range(len - 1, 0); while (!care_bits[flip_k]);
      end
    end
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (pos >= 0 && i >= pos && i < pos + len) begin
        k = i - pos;
        if (care_bits[k]) b = pattern_at(k);
        if (k == flip_k) b = b ^ 8'($urandom_range(255, 1));
      end
      offer_byte(b, i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: length one, all wildcard, base zero. The first byte of a region
  // hits; later bytes stay silent; a one-byte region hits on its final byte.
  task automatic test_reset_defaults();
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'hA5, 1'b1);
  endtask

  // Length field of 31 clamps to 16; full 16-byte match ending on the final byte
  task automatic test_length_clamp();
    program_scan(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, '1, '1, 64'd0);
    send_region(16, REGION_PLANT);
  endtask

  // Length zero acts as one; base of all ones wraps the address; then a miss
  task automatic test_base_wrap();
    program_scan(64'h5A, 64'd0, 64'h1, 64'd0, '1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'h5A, 1'b0);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'hFF, 1'b1);
  endtask

  // Region shorter than the pattern: no position fits, so it ends unmatched
  task automatic test_short_region();
    program_scan(64'h00C3_2211, rand64(), 64'h7, 64'd3, rand64());
    offer_byte(8'h11, 1'b0);
    offer_byte(8'h22, 1'b1);
  endtask

  // Receiver holds off while one-byte regions keep coming, each owing a report,
  // so the pipeline fills and input stalls
  task automatic test_backpressure();
    program_scan(64'h3C, rand64(), 64'h1, 64'h1, rand64());
    steady       = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 48; i++)
      offer_byte(($urandom_range(1) == 1) ? 8'h3C : 8'($urandom_range(255)), 1'b1);
    wait_reports_drained();
    steady = 1'b0;
  endtask

  // Mostly planted regions with random content, some broken, some noise; pause
  // the sender now and then until every report is back
  task automatic test_random_regions(input int items, input bit no_gaps);
    int           sent, regions, n, r;
    region_mode_t mode;
    sent    = 0;
    regions = 0;
    program_random();
    steady  = no_gaps;
    while (sent < items) begin
      n    = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(64, 25);
      r    = $urandom_range(99);
      mode = (r < 55) ? REGION_PLANT : (r < 75) ? REGION_BROKEN : REGION_NOISE;
      send_region(n, mode);
      sent += n;
      regions++;
      if (regions % 12 == 0) wait_reports_drained();
    end
    wait_reports_drained();
    steady = 1'b0;
  endtask

  initial begin
    rearm_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_length_clamp();
    test_base_wrap();
    test_short_region();
    test_backpressure();
    for (int p = 0; p < RANDOM_PHASES; p++)
      test_random_regions(PHASE_ITEMS, p == STEADY_PHASE);
    settle();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("wildcard_byte_pattern_scan: match");
    end else begin
      $display("wildcard_byte_pattern_scan: mismatch");
    end
    $finish;
  end

endmodule
